>>> hw/rtl/pcsb_pkg.sv
// Shared constants, codes, types and the bearing table of the scan binner.
package pcsb_pkg;

   localparam int DEF_BEAM_COUNT   = 360;
   localparam int DEF_CORDIC_STEPS = 20;

   localparam logic [31:0] HEIGHT_LIMIT_RST = 32'd6554;
   localparam logic [31:0] MIN_RANGE_RST    = 32'd6554;
   localparam logic [31:0] MAX_RANGE_RST    = 32'd1310720;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEIGHT_LIMIT = 2'd0,
      REG_MIN_RANGE    = 2'd1,
      REG_MAX_RANGE    = 2'd2
   } csr_reg_type;

   localparam logic CMD_POINT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Angles are fractions of a turn scaled by 2^32, held in 34 signed bits.
   localparam int ANG_W = 34;
   localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sh0_8000_0000;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;

   typedef struct packed {
      logic done;
      logic keep;
   } geom_status_type;

   // atan(2^-i) as a fraction of a turn, scaled by 2^32.
   function automatic logic signed [ANG_W-1:0] turn_step(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         5'd24:   v = 32'h00000029;
         5'd25:   v = 32'h00000014;
         5'd26:   v = 32'h0000000A;
         5'd27:   v = 32'h00000005;
         5'd28:   v = 32'h00000003;
         5'd29:   v = 32'h00000001;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return {2'b00, v};
   endfunction

endpackage

>>> hw/rtl/pcsb_ifs.sv
// Handshake interfaces of the scan binner: point/read requests, beam results, register writes.
interface pcsb_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] x_coord;
   logic [31:0] y_coord;
   logic [31:0] z_coord;
   logic [8:0]  beam_select;

   modport source (output valid, command, x_coord, y_coord, z_coord, beam_select,
                   input ready);
   modport sink   (input valid, command, x_coord, y_coord, z_coord, beam_select,
                   output ready);
endinterface

interface pcsb_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  beam_index;
   logic [31:0] beam_range;
   logic        beam_hit;

   modport source (output valid, beam_index, beam_range, beam_hit, input ready);
   modport sink   (input valid, beam_index, beam_range, beam_hit, output ready);
endinterface

interface pcsb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [31:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

>>> hw/rtl/point_cloud_to_scan_binner.sv
// Top level of the point cloud to planar scan binner.
// Usage of the block:
// The req channel carries one item per point or read. A point item (command 0)
// is gated on |z| against height_limit, its planar range is the floor square
// root of x*x + y*y in Q16.16, and its bearing comes from a vectoring CORDIC.
// Points whose range lies outside [min_range, max_range], or whose bearing maps
// past the last beam, are dropped; otherwise the beam keeps the smaller range.
// A point item that is kept runs from acceptance to write-back through the
// squaring states G_SQX and G_SQY, 32 square-root iterations (the CORDIC runs
// beside them), the beam states G_CHECK and G_BEAM and a read-modify-write of
// the beam memory. It produces no result, and the next item can be accepted in
// the cycle after the write-back. A read item (command 1) passes ST_RD_RD and
// ST_RD_OUT, then raises rsp valid with the beam's range and hit flag and
// clears the beam; the next item can be accepted as rsp valid rises.
// One item is in work at a time; req ready rises again after the last cycle.
// The rsp channel has an output register: a stalled receiver holds the result,
// and a later read item waits only if the register is still full.
// After reset the beam memory is cleared, one beam per cycle, and no request
// is taken until the last beam is clear. Registers (csr channel) are always
// ready and reset to 0.1 m height, 0.1 m minimum and 20 m maximum range.
module point_cloud_to_scan_binner #(
   parameter int BEAM_COUNT   = pcsb_pkg::DEF_BEAM_COUNT,
   parameter int CORDIC_STEPS = pcsb_pkg::DEF_CORDIC_STEPS
) (
   input logic       clock,
   input logic       reset,
   pcsb_req_if.sink  req_bus,
   pcsb_rsp_if.source rsp_bus,
   pcsb_csr_if.sink  csr_bus
);
   import pcsb_pkg::*;

   localparam int AW = $clog2(BEAM_COUNT);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_GEOM   = 7'b0000100,
      ST_UPD_RD = 7'b0001000,
      ST_UPD_WR = 7'b0010000,
      ST_RD_RD  = 7'b0100000,
      ST_RD_OUT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]   height_ff, height_in, minr_ff, minr_in, maxr_ff, maxr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] beam_ff, beam_in;
   logic [31:0]   range_ff, range_in;
   logic [8:0]    sel_ff, sel_in;
   logic          sel_ok_ff, sel_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [8:0]    rsp_index_ff, rsp_index_in;
   logic [31:0]   rsp_range_ff, rsp_range_in;
   logic          rsp_hit_ff, rsp_hit_in;

   // Each beam entry holds {hit, smallest range}.
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [32:0]   ram_wdata, ram_rdata;

   logic                 geom_start;
   geom_status_type      geom_status;
   logic [31:0]          geom_range;
   logic [AW-1:0]        geom_beam;
   logic [AW+8:0]        sel_wide;
   logic                 req_fire;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.beam_index = rsp_index_ff;
   assign rsp_bus.beam_range = rsp_range_ff;
   assign rsp_bus.beam_hit   = rsp_hit_ff;

   pcsb_geom #(
      .BEAM_COUNT   (BEAM_COUNT),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_geom (
      .clock        (clock),
      .reset        (reset),
      .start        (geom_start),
      .x_coord      (req_bus.x_coord),
      .y_coord      (req_bus.y_coord),
      .z_coord      (req_bus.z_coord),
      .height_limit (height_ff),
      .min_range    (minr_ff),
      .max_range    (maxr_ff),
      .status       (geom_status),
      .range_out    (geom_range),
      .beam_out     (geom_beam)
   );

   pcsb_ram #(
      .WIDTH (33),
      .DEPTH (BEAM_COUNT)
   ) u_beam_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Register writes; an index past the last register is ignored.
   always_comb begin
      height_in = height_ff;
      minr_in   = minr_ff;
      maxr_in   = maxr_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            REG_HEIGHT_LIMIT: height_in = csr_bus.wr_data;
            REG_MIN_RANGE:    minr_in   = csr_bus.wr_data;
            REG_MAX_RANGE:    maxr_in   = csr_bus.wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      beam_in      = beam_ff;
      range_in     = range_ff;
      sel_in       = sel_ff;
      sel_ok_in    = sel_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in = rsp_index_ff;
      rsp_range_in = rsp_range_ff;
      rsp_hit_in   = rsp_hit_ff;
      ram_we       = 1'b0;
      ram_waddr    = beam_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = beam_ff;
      geom_start   = 1'b0;
      sel_wide     = {{AW{1'b0}}, req_bus.beam_select};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(BEAM_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.command == CMD_READ) begin
                  sel_in    = req_bus.beam_select;
                  sel_ok_in = sel_wide < (AW + 9)'(BEAM_COUNT);
                  beam_in   = sel_wide[AW-1:0];
                  state_in  = ST_RD_RD;
               end else begin
                  geom_start = 1'b1;
                  state_in   = ST_GEOM;
               end
            end
         end
         ST_GEOM: begin
            if (geom_status.done) begin
               beam_in  = geom_beam;
               range_in = geom_range;
               state_in = geom_status.keep ? ST_UPD_RD : ST_IDLE;
            end
         end
         ST_UPD_RD: begin
            ram_re   = 1'b1;
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            // Keep the smaller range; an empty beam takes any range.
            if (!ram_rdata[32] || (range_ff < ram_rdata[31:0])) begin
               ram_we    = 1'b1;
               ram_wdata = {1'b1, range_ff};
            end
            state_in = ST_IDLE;
         end
         ST_RD_RD: begin
            ram_re   = sel_ok_ff;
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            // Wait here only while the output register still holds a result.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = sel_ff;
               rsp_hit_in   = sel_ok_ff && ram_rdata[32];
               rsp_range_in = (sel_ok_ff && ram_rdata[32]) ? ram_rdata[31:0] : 32'd0;
               ram_we       = sel_ok_ff;
               ram_wdata    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         height_ff    <= HEIGHT_LIMIT_RST;
         minr_ff      <= MIN_RANGE_RST;
         maxr_ff      <= MAX_RANGE_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         height_ff    <= height_in;
         minr_ff      <= minr_in;
         maxr_ff      <= maxr_in;
      end
      beam_ff      <= beam_in;
      range_ff     <= range_in;
      sel_ff       <= sel_in;
      sel_ok_ff    <= sel_ok_in;
      rsp_index_ff <= rsp_index_in;
      rsp_range_ff <= rsp_range_in;
      rsp_hit_ff   <= rsp_hit_in;
   end
endmodule

>>> hw/rtl/pcsb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcsb_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 360
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/pcsb_geom.sv
// Point geometry unit: height gate, squared radius, bit-serial square root, CORDIC bearing, beam.
module pcsb_geom #(
   parameter int BEAM_COUNT   = pcsb_pkg::DEF_BEAM_COUNT,
   parameter int CORDIC_STEPS = pcsb_pkg::DEF_CORDIC_STEPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   x_coord,
   input  logic [31:0]                   y_coord,
   input  logic [31:0]                   z_coord,
   input  logic [31:0]                   height_limit,
   input  logic [31:0]                   min_range,
   input  logic [31:0]                   max_range,
   output pcsb_pkg::geom_status_type     status,
   output logic [31:0]                   range_out,
   output logic [$clog2(BEAM_COUNT)-1:0] beam_out
);
   import pcsb_pkg::*;

   localparam int AW = $clog2(BEAM_COUNT);
   localparam int NW = $clog2(BEAM_COUNT + 1);
   localparam int PW = 33 + NW;
   localparam int CW = 36;

   typedef enum logic [5:0] {
      G_IDLE  = 6'b000001,
      G_SQX   = 6'b000010,
      G_SQY   = 6'b000100,
      G_ITER  = 6'b001000,
      G_CHECK = 6'b010000,
      G_BEAM  = 6'b100000
   } geom_state_type;

   geom_state_type state_ff, state_in;

   logic [31:0]             ax_ff, ax_in, ay_ff, ay_in;
   logic                    zdrop_ff, zdrop_in;
   logic                    axis_ff, axis_in;
   logic                    keep_ff, keep_in;
   logic [63:0]             sq_ff, sq_in, rad_ff, rad_in;
   logic [35:0]             rem_ff, rem_in;
   logic [31:0]             root_ff, root_in;
   logic signed [CW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ANG_W-1:0] cz_ff, cz_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [PW-1:0]           prod_ff, prod_in;

   logic signed [32:0]      zs, xs, ys, az, axs, ays;
   logic [35:0]             rem_sh, trial;
   logic signed [CW-1:0]    dx, dy;
   logic signed [ANG_W-1:0] off;
   logic [NW:0]             beam_full;
   logic                    cordic_on;

   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      zdrop_in  = zdrop_ff;
      axis_in   = axis_ff;
      keep_in   = keep_ff;
      sq_in     = sq_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      status    = '0;

      xs  = {x_coord[31], x_coord};
      ys  = {y_coord[31], y_coord};
      zs  = {z_coord[31], z_coord};
      az  = zs[32] ? -zs : zs;
      axs = xs[32] ? -xs : xs;
      ays = ys[32] ? -ys : ys;

      rem_sh = {rem_ff[33:0], rad_ff[63:62]};
      trial  = {2'b00, root_ff, 2'b01};
      dx     = cy_ff >>> cnt_ff;
      dy     = cx_ff >>> cnt_ff;
      cordic_on = !axis_ff && ({1'b0, cnt_ff} < 6'(CORDIC_STEPS));

      off       = cz_ff + HALF_TURN;
      beam_full = prod_ff[PW-1:32];

      unique case (state_ff)
         G_IDLE: begin
            if (start) begin
               zdrop_in = az[32:0] > {1'b0, height_limit};
               ax_in    = axs[31:0];
               ay_in    = ays[31:0];
               axis_in  = (y_coord == 32'd0);
               cz_in    = '0;
               cx_in    = CW'(xs);
               cy_in    = CW'(ys);
               if (y_coord == 32'd0) begin
                  cz_in = x_coord[31] ? HALF_TURN : '0;
               end else if (x_coord[31]) begin
                  if (!y_coord[31]) begin
                     cx_in = CW'(ys);
                     cy_in = -CW'(xs);
                     cz_in = QUARTER_TURN;
                  end else begin
                     cx_in = -CW'(ys);
                     cy_in = CW'(xs);
                     cz_in = -QUARTER_TURN;
                  end
               end
               state_in = G_SQX;
            end
         end
         G_SQX: begin
            sq_in    = 64'(ax_ff) * 64'(ax_ff);
            state_in = G_SQY;
         end
         G_SQY: begin
            rad_in   = sq_ff + 64'(ay_ff) * 64'(ay_ff);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = G_ITER;
         end
         G_ITER: begin
            // One result bit of the square root per cycle.
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
            rad_in = {rad_ff[61:0], 2'b00};
            // One CORDIC rotation per cycle off the axis, while the shared count < CORDIC_STEPS.
            if (cordic_on) begin
               if (cy_ff > 0) begin
                  cx_in = cx_ff + dx;
                  cy_in = cy_ff - dy;
                  cz_in = cz_ff + turn_step(cnt_ff);
               end else begin
                  cx_in = cx_ff - dx;
                  cy_in = cy_ff + dy;
                  cz_in = cz_ff - turn_step(cnt_ff);
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = G_CHECK;
            end
         end
         G_CHECK: begin
            keep_in  = !zdrop_ff && (root_ff >= min_range) && (root_ff <= max_range);
            prod_in  = off[ANG_W-1] ? '0 : PW'(off[32:0]) * PW'(BEAM_COUNT);
            state_in = G_BEAM;
         end
         G_BEAM: begin
            status.done = 1'b1;
            status.keep = keep_ff && (beam_full < (NW + 1)'(BEAM_COUNT));
            state_in    = G_IDLE;
         end
         default: state_in = G_IDLE;
      endcase
   end

   assign range_out = root_ff;
   assign beam_out  = beam_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      zdrop_ff <= zdrop_in;
      axis_ff  <= axis_in;
      keep_ff  <= keep_in;
      sq_ff    <= sq_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
   end
endmodule

>>> dv/pcsb_checker.sv
// Checker of the scan binner: watches the channels, keeps its own beam table and compares results.
module pcsb_checker (
   input  logic clock,
   input  logic reset,
   pcsb_req_if  req,
   pcsb_rsp_if  rsp,
   pcsb_csr_if  csr,
   output int   errors,
   output int   reports_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import pcsb_pkg::*;

   localparam int BEAMS = DEF_BEAM_COUNT;
   localparam longint HALF  = 64'sd2147483648;
   localparam longint QUART = 64'sd1073741824;

   typedef struct {
      logic [8:0]  beam_index;
      logic [31:0] beam_range;
      logic        beam_hit;
   } beam_report_type;

   beam_report_type report_q[$];
   logic [31:0]  height_lim, range_lo, range_hi;
   logic [31:0]  beam_min [BEAMS];
   bit           beam_seen [BEAMS];

   assign reports_due = report_q.size();

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Bearing as a signed fraction of a turn scaled by 2^32.
   function automatic longint cordic_bearing(input longint x, input longint y);
      longint ang, t, dx, dy;
      if (y == 0) return (x < 0) ? HALF : 0;
      ang = 0;
      if (x < 0) begin
         if (y > 0) begin
            t = x; x = y; y = -t; ang = QUART;
         end else begin
            t = x; x = -y; y = t; ang = -QUART;
         end
      end
      for (int i = 0; i < DEF_CORDIC_STEPS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; ang = ang + longint'(turn_step(i[4:0]));
         end else begin
            x = x - dx; y = y + dy; ang = ang - longint'(turn_step(i[4:0]));
         end
      end
      return ang;
   endfunction

   task automatic bin_point(input logic [31:0] xr, input logic [31:0] yr,
                            input logic [31:0] zr);
      longint x, y, z, off;
      longint unsigned ax, ay, az, rng, beam;
      x = longint'($signed(xr));
      y = longint'($signed(yr));
      z = longint'($signed(zr));
      az = (z < 0) ? -z : z;
      if (az > height_lim) return;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      rng = floor_sqrt(ax * ax + ay * ay);
      if (rng < range_lo || rng > range_hi) return;
      off = cordic_bearing(x, y) + HALF;
      if (off < 0) off = 0;
      beam = (longint'(off) * BEAMS) >> 32;
      if (beam >= BEAMS) return;
      if (!beam_seen[beam] || rng < beam_min[beam]) begin
         beam_min[beam] = rng[31:0];
         beam_seen[beam] = 1'b1;
      end
   endtask

   task automatic read_beam(input logic [8:0] sel);
      beam_report_type r;
      r.beam_index = sel;
      r.beam_range = '0;
      r.beam_hit = 1'b0;
      if (sel < BEAMS) begin
         if (beam_seen[sel]) begin
            r.beam_range = beam_min[sel];
            r.beam_hit = 1'b1;
         end
         beam_seen[sel] = 1'b0;
         beam_min[sel] = '0;
      end
      report_q.push_back(r);
   endtask

   always @(posedge clock) begin
      beam_report_type e;
      int bad;
      bad = 0;
      if (reset) begin
         height_lim <= HEIGHT_LIMIT_RST;
         range_lo <= MIN_RANGE_RST;
         range_hi <= MAX_RANGE_RST;
         for (int i = 0; i < BEAMS; i++) begin
            beam_seen[i] = 1'b0;
            beam_min[i] = '0;
         end
         errors <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.reg_index)
               REG_HEIGHT_LIMIT: height_lim <= csr.wr_data;
               REG_MIN_RANGE:    range_lo <= csr.wr_data;
               REG_MAX_RANGE:    range_hi <= csr.wr_data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (req.command == CMD_READ) read_beam(req.beam_select);
            else bin_point(req.x_coord, req.y_coord, req.z_coord);
         end
         if (rsp.valid && rsp.ready) begin
            if (report_q.size() == 0) begin
               $error("unexpected result: beam_index %0d", rsp.beam_index);
               bad++;
            end else begin
               e = report_q.pop_front();
               if (rsp.beam_index !== e.beam_index) begin
                  $error("beam_index: expected %0d, actual %0d", e.beam_index, rsp.beam_index);
                  bad++;
               end
               if (rsp.beam_range !== e.beam_range) begin
                  $error("beam_range: expected %0d, actual %0d", e.beam_range, rsp.beam_range);
                  bad++;
               end
               if (rsp.beam_hit !== e.beam_hit) begin
                  $error("beam_hit: expected %0d, actual %0d", e.beam_hit, rsp.beam_hit);
                  bad++;
               end
            end
         end
         errors <= errors + bad;
      end
   end
endmodule

>>> dv/tb_top.sv
// Top of the scan binner testbench: clock, reset, stimulus, result stalls and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pcsb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors;
   int   reports_due;

   // Current register settings, mirrored here so that stimulus can aim at the window.
   logic [31:0] cur_height, cur_lo, cur_hi;

   pcsb_req_if req_bus ();
   pcsb_rsp_if rsp_bus ();
   pcsb_csr_if csr_bus ();

   point_cloud_to_scan_binner DUT (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   pcsb_checker checker_inst (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus), .csr(csr_bus),
      .errors(errors), .reports_due(reports_due)
   );

   always #2 clock = ~clock;

   // Mostly no gap, sometimes a short one, rarely a long pause.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The receiver stalls in bursts of random length.
   int stall_left = 0;
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready = 1'b1;
         stall_left = pick_gap();
      end
   end

   // Present one item, after a random gap, and hold it until it is accepted.
   task automatic push_item(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [8:0] sel);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.command = cmd;
      req_bus.x_coord = x;
      req_bus.y_coord = y;
      req_bus.z_coord = z;
      req_bus.beam_select = sel;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      push_item(CMD_POINT, x, y, z, 9'($urandom()));
   endtask

   task automatic read(input logic [8:0] sel);
      push_item(CMD_READ, $urandom(), $urandom(), $urandom(), sel);
   endtask

   // Registers change only while the block is idle. A point item leaves no result,
   // so after the last result the block may still be busy with that point.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_bus.reg_index = idx;
      csr_bus.wr_data = val;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
      case (idx)
         REG_HEIGHT_LIMIT: cur_height = val;
         REG_MIN_RANGE:    cur_lo = val;
         REG_MAX_RANGE:    cur_hi = val;
         default: ;
      endcase
   endtask

   // A coordinate spread evenly over [-lim, lim].
   function automatic logic [31:0] coord(input longint lim);
      longint v;
      v = longint'({$urandom(), $urandom()} % (2 * lim + 1)) - lim;
      return v[31:0];
   endfunction

   // Random traffic: mostly points aimed at the current window, some noise, reads.
   task automatic random_phase(input int n);
      longint lim, hl;
      int p;
      lim = (cur_hi > 32'h4000_0000) ? 64'h4000_0000 : longint'(cur_hi);
      lim = (lim * 3) / 4 + 1;
      hl = (cur_height > 32'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(cur_height);
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         if (p < 65) point(coord(lim), coord(lim), coord(hl));
         else if (p < 75) point($urandom(), $urandom(), $urandom());
         else if (p < 95) read(9'($urandom_range(0, 359)));
         else read(9'($urandom_range(360, 511)));
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = CMD_POINT;
      req_bus.x_coord = '0;
      req_bus.y_coord = '0;
      req_bus.z_coord = '0;
      req_bus.beam_select = '0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = REG_HEIGHT_LIMIT;
      csr_bus.wr_data = '0;
      cur_height = HEIGHT_LIMIT_RST;
      cur_lo = MIN_RANGE_RST;
      cur_hi = MAX_RANGE_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset settings: axis bearings, the half-turn edge,
      // the height gate, extreme coordinates and reads of unknown beams.
      point(32'h0001_0000, 32'h0, 32'h0);          // on the axis, bearing zero
      point(32'hFFFF_0000, 32'h0, 32'h0);          // negative axis, maps past the last beam
      point(32'hFFF0_0000, 32'h0000_0001, 32'h0);  // just below plus half turn
      point(32'hFFF0_0000, 32'hFFFF_FFFF, 32'h0);  // just above minus half turn
      point(32'h0002_0000, 32'h0002_0000, 32'd6554);
      point(32'h0002_0000, 32'h0002_0000, 32'hFFFF_E666); // z = -6554, still allowed
      point(32'h0002_0000, 32'h0001_0000, 32'd6555);      // too high, dropped
      point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      point(32'h0000_1000, 32'h0000_0100, 32'h0);  // below minimum range
      read(9'd180);
      read(9'd0);
      read(9'd359);
      read(9'd225);
      read(9'd360);
      read(9'd511);

      // Wide open window: origin with zero minimum and full-scale coordinates.
      write_reg(REG_MIN_RANGE, 32'h0);
      write_reg(REG_MAX_RANGE, 32'hFFFF_FFFF);
      write_reg(REG_HEIGHT_LIMIT, 32'hFFFF_FFFF);
      write_reg(2'd3, 32'h0000_0001);              // index beyond the last register
      point(32'h0, 32'h0, 32'h0);                  // origin, accepted at bearing zero
      point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      point(32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
      read(9'd180);
      read(9'd45);
      random_phase(350);

      // Narrow window: zero height and a tight ring.
      write_reg(REG_HEIGHT_LIMIT, 32'h0);
      write_reg(REG_MIN_RANGE, 32'h0000_8000);
      write_reg(REG_MAX_RANGE, 32'h0001_0000);
      random_phase(350);

      // Back to the reset values.
      write_reg(REG_HEIGHT_LIMIT, HEIGHT_LIMIT_RST);
      write_reg(REG_MIN_RANGE, MIN_RANGE_RST);
      write_reg(REG_MAX_RANGE, MAX_RANGE_RST);
      random_phase(350);

      // Random settings, including a window that admits nothing.
      write_reg(REG_MIN_RANGE, 32'hFFFF_FFFF);
      write_reg(REG_MAX_RANGE, 32'h0);
      random_phase(50);
      write_reg(REG_HEIGHT_LIMIT, $urandom());
      write_reg(REG_MIN_RANGE, $urandom_range(0, 32'h0004_0000));
      write_reg(REG_MAX_RANGE, $urandom_range(32'h0010_0000, 32'h0400_0000));
      random_phase(300);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/pcsb_pkg.sv
hw/rtl/pcsb_ifs.sv
hw/rtl/pcsb_ram.sv
hw/rtl/pcsb_geom.sv
hw/rtl/point_cloud_to_scan_binner.sv
dv/pcsb_checker.sv
dv/tb_top.sv
